[src/ter_pkg.sv]
// Shared constants for the triangle edge rasterizer.
// No dependencies; every other file imports this package.
`default_nettype none
package ter_pkg;

  // Default sizing of the frame coordinates and the vertex arithmetic
  localparam int unsigned MAX_DIM_BITS = 12;
  localparam int unsigned VERTEX_BITS  = 16;

  // Fixed port field widths
  localparam int unsigned FIELD_BITS   = 16;
  localparam int unsigned COLOUR_BITS  = 32;
  localparam int unsigned PIX_BITS     = 12;
  localparam int unsigned CFG_BITS     = 13;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Register indexes and reset values
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_BITS-1:0]     FRAME_W_RESET    = 13'd640;
  localparam logic [CFG_BITS-1:0]     FRAME_H_RESET    = 13'd480;

  // Item operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QCNT_BITS   = 4;

endpackage
`default_nettype wire

[src/ter_if.sv]
// Handshake channel interfaces: triangle items, pixel items, register writes.
// Depends on ter_pkg for field widths.
`default_nettype none
interface ter_item_if;
  import ter_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [FIELD_BITS-1:0]  vertex_a_x;
  logic signed [FIELD_BITS-1:0]  vertex_a_y;
  logic signed [FIELD_BITS-1:0]  vertex_b_x;
  logic signed [FIELD_BITS-1:0]  vertex_b_y;
  logic signed [FIELD_BITS-1:0]  vertex_c_x;
  logic signed [FIELD_BITS-1:0]  vertex_c_y;
  logic        [COLOUR_BITS-1:0] fill_colour_in;
  modport source(output valid, op, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                 vertex_c_x, vertex_c_y, fill_colour_in, input ready);
  modport sink(input valid, op, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_colour_in, output ready);
endinterface

interface ter_pixel_if;
  import ter_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PIX_BITS-1:0]    pixel_x;
  logic [PIX_BITS-1:0]    pixel_y;
  logic                   covered;
  logic [COLOUR_BITS-1:0] pixel_colour;
  logic                   last;
  modport source(output valid, pixel_x, pixel_y, covered, pixel_colour, last,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, covered, pixel_colour, last,
               output ready);
endinterface

interface ter_cfg_if;
  import ter_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0]     wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

[src/ter_front.sv]
// Front part: accepts items, holds the frame registers, sets up the box and
// the edge values over three stages and pushes commands. Uses ter_pkg, ter_if.
`default_nettype none
module ter_front #(
  parameter int unsigned M = ter_pkg::MAX_DIM_BITS,
  parameter int unsigned V = ter_pkg::VERTEX_BITS,
  parameter type cmd_t = logic
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  ter_item_if.sink                      in_i,
  ter_cfg_if.sink                       cfg_i,
  input  wire logic [ter_pkg::QCNT_BITS-1:0] q_count_i,
  output logic                          push_o,
  output cmd_t                          cmd_o
);
  import ter_pkg::*;

  localparam int unsigned DW = V + 1;
  localparam int unsigned PW = 2 * V + 2;
  localparam int unsigned EW = 2 * V + 3;
  localparam int unsigned MW = (V > FIELD_BITS) ? V : FIELD_BITS;
  localparam int unsigned BW = ((V + 1 > M + 2) ? V + 1 : M + 2) + 1;
  localparam int unsigned LW = (CFG_BITS > M + 1) ? CFG_BITS : M + 1;
  localparam logic [LW-1:0] CAP = LW'(1) << M;
  localparam logic signed [BW-1:0] ONE_S = BW'(1);
  localparam logic signed [BW-1:0] ZERO_S = '0;

  function automatic logic signed [V-1:0] vtx(input logic [FIELD_BITS-1:0] f);
    logic [MW-1:0] w;
    w = MW'(f);
    return signed'(w[V-1:0]);
  endfunction

  function automatic logic [LW-1:0] lim(input logic [CFG_BITS-1:0] r);
    logic [LW-1:0] w;
    w = LW'(r);
    return (w > CAP) ? CAP : w;
  endfunction

  // Frame registers, always writable
  logic [CFG_BITS-1:0] fw_q, fh_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_W_RESET;
      fh_q <= FRAME_H_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == REG_FRAME_WIDTH) fw_q <= cfg_i.wdata;
      if (cfg_i.reg_index == REG_FRAME_HEIGHT) fh_q <= cfg_i.wdata;
    end
  end

  // Credit check: queue entries plus items in flight
  logic a_vld_q, b_vld_q, c_vld_q;
  logic [QCNT_BITS:0] used;
  logic accept;
  assign used = (QCNT_BITS + 1)'(q_count_i) + (QCNT_BITS + 1)'(a_vld_q)
              + (QCNT_BITS + 1)'(b_vld_q) + (QCNT_BITS + 1)'(c_vld_q);
  assign in_i.ready = used < (QCNT_BITS + 1)'(QUEUE_DEPTH);
  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // Stage A: capture the item
  logic a_op_q;
  logic signed [V-1:0] a_ax_q, a_ay_q, a_bx_q, a_by_q, a_cx_q, a_cy_q;
  logic [COLOUR_BITS-1:0] a_col_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q  <= in_i.op;
      a_ax_q  <= vtx(in_i.vertex_a_x);
      a_ay_q  <= vtx(in_i.vertex_a_y);
      a_bx_q  <= vtx(in_i.vertex_b_x);
      a_by_q  <= vtx(in_i.vertex_b_y);
      a_cx_q  <= vtx(in_i.vertex_c_x);
      a_cy_q  <= vtx(in_i.vertex_c_y);
      a_col_q <= in_i.fill_colour_in;
    end
  end

  // Stage B logic: deltas and clamped box
  logic signed [V-1:0] mnx, mny, mxx, mxy;
  logic signed [BW-1:0] limx, limy, ux, uy, x0, y0, x1, y1;
  always_comb begin
    mnx = (a_ax_q < a_bx_q) ? a_ax_q : a_bx_q;
    mnx = (mnx < a_cx_q) ? mnx : a_cx_q;
    mny = (a_ay_q < a_by_q) ? a_ay_q : a_by_q;
    mny = (mny < a_cy_q) ? mny : a_cy_q;
    mxx = (a_ax_q > a_bx_q) ? a_ax_q : a_bx_q;
    mxx = (mxx > a_cx_q) ? mxx : a_cx_q;
    mxy = (a_ay_q > a_by_q) ? a_ay_q : a_by_q;
    mxy = (mxy > a_cy_q) ? mxy : a_cy_q;
    limx = BW'($signed({1'b0, lim(fw_q)}));
    limy = BW'($signed({1'b0, lim(fh_q)}));
    ux = BW'(mxx) + ONE_S;
    uy = BW'(mxy) + ONE_S;
    x1 = (ux > limx) ? limx : ux;
    y1 = (uy > limy) ? limy : uy;
    if (x1 < ZERO_S) x1 = ZERO_S;
    if (y1 < ZERO_S) y1 = ZERO_S;
    x0 = (mnx < 0) ? ZERO_S : BW'(mnx);
    y0 = (mny < 0) ? ZERO_S : BW'(mny);
  end

  logic b_op_q, b_live_q;
  logic [M-1:0] b_x0_q, b_y0_q;
  logic [M:0] b_x1_q, b_y1_q;
  logic signed [DW-1:0] b_dabx_q, b_daby_q, b_dacx_q, b_dacy_q, b_px_q, b_py_q;
  logic [COLOUR_BITS-1:0] b_col_q;
  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_op_q   <= a_op_q;
      b_live_q <= (x0 < x1) && (y0 < y1);
      b_x0_q   <= x0[M-1:0];
      b_y0_q   <= y0[M-1:0];
      b_x1_q   <= x1[M:0];
      b_y1_q   <= y1[M:0];
      b_dabx_q <= DW'(a_bx_q) - DW'(a_ax_q);
      b_daby_q <= DW'(a_by_q) - DW'(a_ay_q);
      b_dacx_q <= DW'(a_cx_q) - DW'(a_ax_q);
      b_dacy_q <= DW'(a_cy_q) - DW'(a_ay_q);
      b_px_q   <= DW'(x0 - BW'(a_ax_q));
      b_py_q   <= DW'(y0 - BW'(a_ay_q));
      b_col_q  <= a_col_q;
    end
  end

  // Stage C: six products
  logic c_op_q, c_live_q;
  logic [M-1:0] c_x0_q, c_y0_q;
  logic [M:0] c_x1_q, c_y1_q;
  logic signed [DW-1:0] c_dabx_q, c_daby_q, c_dacx_q, c_dacy_q;
  logic signed [PW-1:0] c_d1_q, c_d2_q, c_e1a_q, c_e1b_q, c_e2a_q, c_e2b_q;
  logic [COLOUR_BITS-1:0] c_col_q;
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      c_op_q   <= b_op_q;
      c_live_q <= b_live_q;
      c_x0_q   <= b_x0_q;
      c_y0_q   <= b_y0_q;
      c_x1_q   <= b_x1_q;
      c_y1_q   <= b_y1_q;
      c_dabx_q <= b_dabx_q;
      c_daby_q <= b_daby_q;
      c_dacx_q <= b_dacx_q;
      c_dacy_q <= b_dacy_q;
      c_d1_q   <= PW'(b_dabx_q) * PW'(b_dacy_q);
      c_d2_q   <= PW'(b_dacx_q) * PW'(b_daby_q);
      c_e1a_q  <= PW'(b_px_q) * PW'(b_dacy_q);
      c_e1b_q  <= PW'(b_dacx_q) * PW'(b_py_q);
      c_e2a_q  <= PW'(b_dabx_q) * PW'(b_py_q);
      c_e2b_q  <= PW'(b_px_q) * PW'(b_daby_q);
      c_col_q  <= b_col_q;
    end
  end

  // Form the command from the products
  assign push_o = c_vld_q;
  always_comb begin
    cmd_o.is_load = (c_op_q == OP_LOAD);
    cmd_o.live    = c_live_q;
    cmd_o.x0      = c_x0_q;
    cmd_o.y0      = c_y0_q;
    cmd_o.x1      = c_x1_q;
    cmd_o.y1      = c_y1_q;
    cmd_o.dabx    = c_dabx_q;
    cmd_o.daby    = c_daby_q;
    cmd_o.dacx    = c_dacx_q;
    cmd_o.dacy    = c_dacy_q;
    cmd_o.det     = EW'(c_d1_q) - EW'(c_d2_q);
    cmd_o.e1      = EW'(c_e1a_q) - EW'(c_e1b_q);
    cmd_o.e2      = EW'(c_e2a_q) - EW'(c_e2b_q);
    cmd_o.colour  = c_col_q;
  end

endmodule
`default_nettype wire

[src/ter_queue.sv]
// Command queue between the front and back parts.
// Uses ter_pkg for depth and count width.
`default_nettype none
module ter_queue #(
  parameter type cmd_t = logic
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire cmd_t                          data_i,
  input  wire logic                          pop_i,
  output logic                               valid_o,
  output cmd_t                               data_o,
  output logic [ter_pkg::QCNT_BITS-1:0]      count_o
);
  import ter_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  cmd_t mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  // Store on push; the front never pushes into a full queue
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + QCNT_BITS'(push_i) - QCNT_BITS'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

[src/ter_back.sv]
// Back part: runs the active triangle, walks the box and registers pixels.
// Uses ter_pkg and ter_pixel_if.
`default_nettype none
module ter_back #(
  parameter int unsigned M = ter_pkg::MAX_DIM_BITS,
  parameter int unsigned V = ter_pkg::VERTEX_BITS,
  parameter type cmd_t = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire cmd_t cmd_i,
  output logic      pop_o,
  ter_pixel_if.source out_o
);
  import ter_pkg::*;

  localparam int unsigned DW  = V + 1;
  localparam int unsigned EW  = 2 * V + 3;
  localparam int unsigned PXW = (M > PIX_BITS) ? M : PIX_BITS;

  logic act_q;
  logic [M-1:0] xs_q, cx_q, cy_q;
  logic [M:0] xe_q, ye_q;
  logic signed [DW-1:0] dabx_q, daby_q, dacx_q, dacy_q;
  logic signed [EW-1:0] det_q, e1_q, e2_q, r1_q, r2_q;
  logic [COLOUR_BITS-1:0] col_q;

  logic out_vld_q;
  logic [PIX_BITS-1:0] px_q, py_q;
  logic cov_q, last_q;
  logic [COLOUR_BITS-1:0] pcol_q;

  logic out_free, emit, row_more, fin, cov;
  logic signed [EW:0] esum, dext;
  logic [PXW-1:0] cx_w, cy_w;

  assign out_free = !out_vld_q || out_o.ready;
  assign pop_o    = q_valid_i && out_free;
  assign emit     = pop_o && !cmd_i.is_load && act_q;

  // Coverage with the sign of D folded into the compares
  always_comb begin
    esum = (EW + 1)'(e1_q) + (EW + 1)'(e2_q);
    dext = (EW + 1)'(det_q);
    if (det_q < 0) cov = (e1_q <= 0) && (e2_q <= 0) && (esum >= dext);
    else cov = (e1_q >= 0) && (e2_q >= 0) && (esum <= dext);
    row_more = ((M + 1)'(cx_q) + (M + 1)'(1)) < xe_q;
    fin = !row_more && (((M + 1)'(cy_q) + (M + 1)'(1)) >= ye_q);
    cx_w = PXW'(cx_q);
    cy_w = PXW'(cy_q);
  end

  // Triangle state: load replaces, step advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (pop_o && cmd_i.is_load) begin
      act_q <= cmd_i.live;
    end else if (emit && fin) begin
      act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.is_load) begin
      xs_q   <= cmd_i.x0;
      cx_q   <= cmd_i.x0;
      cy_q   <= cmd_i.y0;
      xe_q   <= cmd_i.x1;
      ye_q   <= cmd_i.y1;
      dabx_q <= cmd_i.dabx;
      daby_q <= cmd_i.daby;
      dacx_q <= cmd_i.dacx;
      dacy_q <= cmd_i.dacy;
      det_q  <= cmd_i.det;
      e1_q   <= cmd_i.e1;
      e2_q   <= cmd_i.e2;
      r1_q   <= cmd_i.e1;
      r2_q   <= cmd_i.e2;
      col_q  <= cmd_i.colour;
    end else if (emit) begin
      if (row_more) begin
        cx_q <= cx_q + M'(1);
        e1_q <= e1_q + EW'(dacy_q);
        e2_q <= e2_q - EW'(daby_q);
      end else begin
        cx_q <= xs_q;
        cy_q <= cy_q + M'(1);
        r1_q <= r1_q - EW'(dacx_q);
        r2_q <= r2_q + EW'(dabx_q);
        e1_q <= r1_q - EW'(dacx_q);
        e2_q <= r2_q + EW'(dabx_q);
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= cx_w[PIX_BITS-1:0];
      py_q   <= cy_w[PIX_BITS-1:0];
      cov_q  <= cov;
      pcol_q <= cov ? col_q : '0;
      last_q <= fin;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.pixel_x      = px_q;
  assign out_o.pixel_y      = py_q;
  assign out_o.covered      = cov_q;
  assign out_o.pixel_colour = pcol_q;
  assign out_o.last         = last_q;

endmodule
`default_nettype wire

[src/triangle_edge_rasterizer_core.sv]
// Top level of the triangle edge rasterizer: front, command queue, back.
// Uses ter_pkg, ter_if, ter_front, ter_queue, ter_back.
//
//  channel | dir | payload                                 | accepted when
//  in_i    | in  | op, three vertices, fill_colour_in      | valid && ready
//  out_o   | out | pixel_x, pixel_y, covered, colour, last | valid && ready
//  cfg_i   | in  | reg_index, wdata (13 bit)               | valid (ready tied high)
//
// One item per cycle sustained while the queue has room; every item passes three setup
// stages (capture, box clamp, products) and the queue, and a step item's pixel then
// passes the output register of the back part.
// The front stops taking items when queue entries plus items in setup reach
// eight. Reset clears control state only; no clearing pass is needed.
`default_nettype none
module triangle_edge_rasterizer_core #(
  parameter int unsigned MAX_DIM_BITS = ter_pkg::MAX_DIM_BITS,
  parameter int unsigned VERTEX_BITS  = ter_pkg::VERTEX_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ter_item_if.sink    in_i,
  ter_cfg_if.sink     cfg_i,
  ter_pixel_if.source out_o
);
  import ter_pkg::*;

  localparam int unsigned DW = VERTEX_BITS + 1;
  localparam int unsigned EW = 2 * VERTEX_BITS + 3;

  typedef struct packed {
    logic                   is_load;
    logic                   live;
    logic [MAX_DIM_BITS-1:0] x0;
    logic [MAX_DIM_BITS-1:0] y0;
    logic [MAX_DIM_BITS:0]   x1;
    logic [MAX_DIM_BITS:0]   y1;
    logic signed [DW-1:0]   dabx;
    logic signed [DW-1:0]   daby;
    logic signed [DW-1:0]   dacx;
    logic signed [DW-1:0]   dacy;
    logic signed [EW-1:0]   det;
    logic signed [EW-1:0]   e1;
    logic signed [EW-1:0]   e2;
    logic [COLOUR_BITS-1:0] colour;
  } cmd_t;

  logic push, pop, q_valid;
  cmd_t push_cmd, head_cmd;
  logic [QCNT_BITS-1:0] q_count;

  ter_front #(.M(MAX_DIM_BITS), .V(VERTEX_BITS), .cmd_t(cmd_t)) u_front (
    .clk_i, .rst_ni, .in_i, .cfg_i,
    .q_count_i(q_count), .push_o(push), .cmd_o(push_cmd)
  );

  ter_queue #(.cmd_t(cmd_t)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_cmd), .pop_i(pop),
    .valid_o(q_valid), .data_o(head_cmd), .count_o(q_count)
  );

  ter_back #(.M(MAX_DIM_BITS), .V(VERTEX_BITS), .cmd_t(cmd_t)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .cmd_i(head_cmd), .pop_o(pop), .out_o
  );

endmodule
`default_nettype wire

[src/ter_checker.sv]
// Port-level checks for the rasterizer top level, attached by bind.
// Uses ter_pkg for register indexes and reset values.
`default_nettype none
module ter_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_valid_i,
  input wire logic cfg_ready_i,
  input wire logic [ter_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input wire logic [ter_pkg::CFG_BITS-1:0] cfg_data_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [ter_pkg::PIX_BITS-1:0] pixel_x_i,
  input wire logic [ter_pkg::PIX_BITS-1:0] pixel_y_i,
  input wire logic covered_i,
  input wire logic [ter_pkg::COLOUR_BITS-1:0] pixel_colour_i
);
  import ter_pkg::*;

  // Track the frame size as seen on the register port
  logic [CFG_BITS-1:0] fw_q, fh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_W_RESET;
      fh_q <= FRAME_H_RESET;
    end else if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i == REG_FRAME_WIDTH) fw_q <= cfg_data_i;
      if (cfg_index_i == REG_FRAME_HEIGHT) fh_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_x_i)
      && $stable(pixel_y_i) && $stable(pixel_colour_i))
    else $error("pixel item changed while stalled");

  a_uncovered_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !covered_i |-> pixel_colour_i == '0)
    else $error("uncovered pixel carries a colour");

  a_x_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> CFG_BITS'(pixel_x_i) < fw_q)
    else $error("pixel x outside frame");

  a_y_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> CFG_BITS'(pixel_y_i) < fh_q)
    else $error("pixel y outside frame");

endmodule

bind triangle_edge_rasterizer_core ter_checker u_ter_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .cfg_valid_i(cfg_i.valid),
  .cfg_ready_i(cfg_i.ready),
  .cfg_index_i(cfg_i.reg_index),
  .cfg_data_i(cfg_i.wdata),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .pixel_x_i(out_o.pixel_x),
  .pixel_y_i(out_o.pixel_y),
  .covered_i(out_o.covered),
  .pixel_colour_i(out_o.pixel_colour)
);
`default_nettype wire

[tb/sv/tb_ter_checker.sv]
// Pixel checker for the triangle edge rasterizer: watches the item, register
// and pixel channels, predicts every pixel and compares. Depends on ter_pkg, ter_if.
`timescale 1ns / 1ps
module tb_ter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ter_item_if.sink    in_mon,
  ter_cfg_if.sink     cfg_mon,
  ter_pixel_if.sink   out_mon,
  output int          fail_count,
  output int          pending_count,
  output int          pixel_count,
  output int          covered_count
);
  import ter_pkg::*;

  typedef struct packed {
    logic [PIX_BITS-1:0]    x;
    logic [PIX_BITS-1:0]    y;
    logic                   cov;
    logic [COLOUR_BITS-1:0] colour;
    logic                   last;
  } pixel_t;

  pixel_t pixel_queue[$];

  // Rasterizer shadow state
  logic [CFG_BITS-1:0] width_reg, height_reg;
  bit          tri_active;
  longint      x_start, x_end, y_end, cur_x, cur_y;
  longint      det, e1, e2, row_e1, row_e2;
  longint      ab_x, ab_y, ac_x, ac_y;
  logic [31:0] colour_held;

  assign pending_count = pixel_queue.size();

  function automatic longint clamp_size(logic [CFG_BITS-1:0] r);
    longint cap;
    cap = longint'(1) << MAX_DIM_BITS;
    return (longint'(r) > cap) ? cap : longint'(r);
  endfunction

  task automatic load_triangle();
    longint ax, ay, bx, by, cx, cy, x0, y0, x1, y1, px, py;
    ax = in_mon.vertex_a_x; ay = in_mon.vertex_a_y;
    bx = in_mon.vertex_b_x; by = in_mon.vertex_b_y;
    cx = in_mon.vertex_c_x; cy = in_mon.vertex_c_y;
    x0 = ax < bx ? ax : bx; x0 = x0 < cx ? x0 : cx;
    y0 = ay < by ? ay : by; y0 = y0 < cy ? y0 : cy;
    x1 = ax > bx ? ax : bx; x1 = (x1 > cx ? x1 : cx) + 1;
    y1 = ay > by ? ay : by; y1 = (y1 > cy ? y1 : cy) + 1;
    if (x1 > clamp_size(width_reg)) x1 = clamp_size(width_reg);
    if (y1 > clamp_size(height_reg)) y1 = clamp_size(height_reg);
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    tri_active = 0;
    if (x0 >= x1 || y0 >= y1) return;
    ab_x = bx - ax; ab_y = by - ay; ac_x = cx - ax; ac_y = cy - ay;
    det = ab_x * ac_y - ac_x * ab_y;
    px = x0 - ax; py = y0 - ay;
    row_e1 = px * ac_y - ac_x * py;
    row_e2 = ab_x * py - px * ab_y;
    e1 = row_e1; e2 = row_e2;
    x_start = x0; x_end = x1; y_end = y1; cur_x = x0; cur_y = y0;
    colour_held = in_mon.fill_colour_in;
    tri_active = 1;
  endtask

  task automatic step_pixel();
    pixel_t p;
    longint d, a, b;
    bit fin;
    if (!tri_active) return;
    d = det; a = e1; b = e2;
    if (d < 0) begin
      d = -d; a = -a; b = -b;
    end
    p.cov = (a >= 0) && (b >= 0) && (a + b <= d);
    fin = (cur_x + 1 >= x_end) && (cur_y + 1 >= y_end);
    p.x = cur_x[PIX_BITS-1:0];
    p.y = cur_y[PIX_BITS-1:0];
    p.colour = p.cov ? colour_held : '0;
    p.last = fin;
    pixel_queue.push_back(p);
    if (cur_x + 1 < x_end) begin
      cur_x++; e1 += ac_y; e2 -= ab_y;
    end else begin
      cur_x = x_start; cur_y++;
      row_e1 -= ac_x; row_e2 += ab_x;
      e1 = row_e1; e2 = row_e2;
      if (fin) tri_active = 0;
    end
  endtask

  // Predict on accepted items, compare accepted pixels
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      width_reg = FRAME_W_RESET; height_reg = FRAME_H_RESET;
      tri_active = 0;
      pixel_queue.delete();
      fail_count = 0; pixel_count = 0; covered_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        pixel_count++;
        if (pixel_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected pixel x=%0d y=%0d",
                                         out_mon.pixel_x, out_mon.pixel_y);
        end else begin
          want = pixel_queue.pop_front();
          if (want.cov) covered_count++;
          if (want.x !== out_mon.pixel_x || want.y !== out_mon.pixel_y ||
              want.cov !== out_mon.covered || want.colour !== out_mon.pixel_colour ||
              want.last !== out_mon.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: exp x=%0d y=%0d c=%0b col=%h l=%0b got x=%0d y=%0d c=%0b col=%h l=%0b",
                       want.x, want.y, want.cov, want.colour, want.last,
                       out_mon.pixel_x, out_mon.pixel_y, out_mon.covered,
                       out_mon.pixel_colour, out_mon.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == OP_LOAD) load_triangle();
        else step_pixel();
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == REG_FRAME_WIDTH) width_reg = cfg_mon.wdata;
        else if (cfg_mon.reg_index == REG_FRAME_HEIGHT) height_reg = cfg_mon.wdata;
      end
    end
  end
endmodule

[tb/sv/tb_top.sv]
// Top of the triangle edge rasterizer testbench: clock, reset, item and
// register stimulus, pixel sink stalls, verdict. Depends on tb_ter_checker.
`timescale 1ns / 1ps
module tb_top;
  import ter_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 0;
  logic rst_ni = 0;
  int   fail_count, pending_count, pixel_count, covered_count;
  int   cycle_count = 0;
  int   items_sent = 0;
  bit   hold_off = 0;
  bit   sink_busy = 1;

  ter_item_if  in_if();
  ter_cfg_if   cfg_if();
  ter_pixel_if out_if();

  triangle_edge_rasterizer_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .cfg_i(cfg_if.sink),
    .out_o(out_if.source)
  );

  tb_ter_checker checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_if.sink), .cfg_mon(cfg_if.sink),
    .out_mon(out_if.sink), .fail_count(fail_count), .pending_count(pending_count),
    .pixel_count(pixel_count), .covered_count(covered_count)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Pixel sink: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    int n;
    if (hold_off || !sink_busy) out_if.ready <= 0;
    else begin
      n = gap_len();
      out_if.ready <= (n == 0) || ($urandom_range(0, 1) == 0);
    end
  end

  function automatic logic signed [15:0] coord(bit wide);
    if (wide) return 16'($urandom);
    return 16'($signed($urandom_range(0, 40)) - 8);
  endfunction

  // Drop valid only inside a gap, so each edge sees one assignment to it
  task automatic send_item(logic op, logic signed [15:0] ax, ay, bx, by, cx, cy,
                           logic [31:0] colour);
    int n;
    n = gap_len();
    repeat (n) begin
      in_if.valid <= 0;
      @(posedge clk_i);
    end
    in_if.valid <= 1; in_if.op <= op;
    in_if.vertex_a_x <= ax; in_if.vertex_a_y <= ay;
    in_if.vertex_b_x <= bx; in_if.vertex_b_y <= by;
    in_if.vertex_c_x <= cx; in_if.vertex_c_y <= cy;
    in_if.fill_colour_in <= colour;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_steps(int n);
    repeat (n) send_item(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    cfg_if.valid <= 1; cfg_if.reg_index <= idx; cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 0;
  endtask

  // Stop offering items, wait for all pixels, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_triangle(bit wide);
    send_item(OP_LOAD, coord(wide), coord(wide), coord(wide), coord(wide),
              coord(wide), coord(wide), $urandom);
  endtask

  initial begin
    int k, extra;
    in_if.valid = 0; in_if.op = OP_STEP;
    {in_if.vertex_a_x, in_if.vertex_a_y, in_if.vertex_b_x} = '0;
    {in_if.vertex_b_y, in_if.vertex_c_x, in_if.vertex_c_y} = '0;
    in_if.fill_colour_in = 0;
    cfg_if.valid = 0; cfg_if.reg_index = REG_FRAME_WIDTH; cfg_if.wdata = 0;
    out_if.ready = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: step while idle, normal, degenerate, clipped, reversed winding
    send_steps(2);
    send_item(OP_LOAD, 0, 0, 4, 0, 0, 3, 32'hFFFF_FFFF);
    send_steps(20);
    send_item(OP_LOAD, 1, 1, 3, 3, 5, 5, 32'h1234_5678);
    send_steps(5);
    send_item(OP_LOAD, 0, 0, 0, 3, 3, 0, 32'h8000_0001); // load over a running one
    send_item(OP_LOAD, -32768, -32768, 32767, -32768, -32768, 32767, 32'hA5A5_A5A5);
    send_steps(3);
    send_item(OP_LOAD, -5, -5, -1, -2, -3, -1, 32'h0); // box fully off frame
    send_steps(2);
    send_item(OP_LOAD, 32767, 32767, 32767, 32767, 32767, 32767, 32'h0);
    send_steps(1);
    drain();

    // Register extremes: minimum, zero, and oversized (saturates)
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    send_item(OP_LOAD, 0, 0, 5, 0, 0, 5, 32'h5555_AAAA);
    send_steps(3);
    drain();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    send_item(OP_LOAD, 0, 0, 5, 0, 0, 5, 32'h1);
    send_steps(2);
    drain();
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_item(OP_LOAD, 4093, 4094, 4100, 4094, 4093, 4098, 32'hDEAD_BEEF);
    send_steps(12);
    drain();

    // Back-pressure: sink holds off while steps keep coming
    write_reg(REG_FRAME_WIDTH, 13'd4096);
    write_reg(REG_FRAME_HEIGHT, 13'd16);
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        send_item(OP_LOAD, 0, 0, 40, 2, 5, 10, 32'hCAFE_F00D);
        send_steps(30);
      end
    join
    drain();

    // Random phases with several frame settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_FRAME_WIDTH,
                (ph == 3) ? 13'h1FFF : CFG_BITS'($urandom_range(1, 64)));
      write_reg(REG_FRAME_HEIGHT,
                (ph == 3) ? 13'd4096 : CFG_BITS'($urandom_range(1, 64)));
      for (k = 0; k < 4; k++) begin
        random_triangle($urandom_range(0, 9) == 0);
        extra = $urandom_range(0, 3) == 0 ? -3 : $urandom_range(0, 4);
        send_steps($urandom_range(3, 25) + extra + 3);
        if ($urandom_range(0, 5) == 0) send_steps(0);
      end
      drain();
    end
    sink_busy = 1;

    $display("covered %0d items, %0d pixels checked, %0d covered",
             items_sent, pixel_count, covered_count);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
